FILE: rtl/mfam_pkg.sv
// Shared types and constants for the minifloat add/multiply/compare pipeline.
package mfam_pkg;

  localparam int SIG_W = 10;
  localparam int MAG_W = 41;
  localparam int SUM_W = 42;
  localparam int PROD_W = 20;
  localparam int Q_W = 40;
  localparam int QN_W = 25;
  localparam int EX_W = 4;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_MUL = 2'd1;
  localparam logic [1:0] ACT_EQ  = 2'd2;
  localparam logic [1:0] ACT_GT  = 2'd3;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_OVER  = 2'd1;
  localparam logic [1:0] ERR_UNDER = 2'd2;

  // 32736 * 1024
  localparam logic [Q_W-1:0] Q_LIMIT = Q_W'(33521664);

  typedef struct packed {
    logic [1:0]              action;
    logic                    neg_a;
    logic                    neg_b;
    logic                    zero_a;
    logic                    zero_b;
    logic [MAG_W-1:0]        mag_a;
    logic [MAG_W-1:0]        mag_b;
    logic [PROD_W-1:0]       prod;
    logic signed [5:0]       exp_sum;
  } s1_t;

  typedef struct packed {
    logic            neg;
    logic [Q_W-1:0]  q;
    logic            rem;
    logic            under;
    logic            flag;
  } s2_t;

  typedef struct packed {
    logic             neg;
    logic [QN_W-1:0]  q;
    logic [EX_W-1:0]  ex;
    logic [1:0]       err;
    logic             flag;
  } s3_t;

  typedef struct packed {
    logic [15:0] result_word;
    logic        compare_flag;
    logic [1:0]  error_code;
  } res_t;

endpackage

FILE: rtl/minifloat16_add_mul_compare_top.sv
// Top level of the 16-bit minifloat add/multiply/compare unit.
//
//  channel   dir  tdata (low bit up)                                tuser
//  s_axis    in   operand_a[15:0], operand_b[31:16]                 action[1:0]
//  m_axis    out  result_word[15:0], compare_flag[16],              -
//                 error_code[18:17], zero pad[23:19]
//
// One word per cycle sustained while m_axis_tready is held high, through the
// four register stages (decode/multiply, add/scale, limit check, pack).
// Each stage holds a valid bit; rst clears them all synchronously.
// A stall on m_axis holds the output register; upstream stages keep filling
// empty slots, so s_axis stays ready until the pipe is full.
module minifloat16_add_mul_compare_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // operand_a, operand_b
  input  logic [1:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // result_word, compare_flag, error_code, pad
);

  logic           v1;
  logic           v2;
  logic           v3;
  logic           r2;
  logic           r3;
  logic           r4;
  mfam_pkg::s1_t  d1;
  mfam_pkg::s2_t  d2;
  mfam_pkg::s3_t  d3;
  mfam_pkg::res_t res;

  mfam_unpack u_unpack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .action    (s_axis_tuser),
    .operand_a (s_axis_tdata[15:0]),
    .operand_b (s_axis_tdata[31:16]),
    .out_valid (v1),
    .out_ready (r2),
    .out_data  (d1)
  );

  mfam_combine u_combine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (r2),
    .in_data   (d1),
    .out_valid (v2),
    .out_ready (r3),
    .out_data  (d2)
  );

  mfam_limit u_limit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (r3),
    .in_data   (d2),
    .out_valid (v3),
    .out_ready (r4),
    .out_data  (d3)
  );

  mfam_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_ready  (r4),
    .in_data   (d3),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res)
  );

  assign m_axis_tdata = {5'b0, res.error_code, res.compare_flag, res.result_word};

endmodule

FILE: rtl/mfam_unpack.sv
// Stage 1: operand decode into fixed-point magnitudes and significand product.
module mfam_unpack (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        action,
  input  logic [15:0]       operand_a,
  input  logic [15:0]       operand_b,
  output logic              out_valid,
  input  logic              out_ready,
  output mfam_pkg::s1_t     out_data
);

  logic [mfam_pkg::SIG_W-1:0] sig_a;
  logic [mfam_pkg::SIG_W-1:0] sig_b;
  logic [4:0]                 sh_a;
  logic [4:0]                 sh_b;
  mfam_pkg::s1_t              data_next;

  assign in_ready = !out_valid || out_ready;

  assign sig_a = operand_a[9:0];
  assign sig_b = operand_b[9:0];
  // exponent + 16
  assign sh_a = {~operand_a[14], operand_a[13:10]};
  assign sh_b = {~operand_b[14], operand_b[13:10]};

  always_comb begin
    data_next.action  = action;
    data_next.neg_a   = operand_a[15];
    data_next.neg_b   = operand_b[15];
    data_next.zero_a  = (sig_a == '0);
    data_next.zero_b  = (sig_b == '0);
    data_next.mag_a   = mfam_pkg::MAG_W'(sig_a) << sh_a;
    data_next.mag_b   = mfam_pkg::MAG_W'(sig_b) << sh_b;
    data_next.prod    = mfam_pkg::PROD_W'(sig_a) * mfam_pkg::PROD_W'(sig_b);
    data_next.exp_sum = $signed({operand_a[14], operand_a[14:10]})
                      + $signed({operand_b[14], operand_b[14:10]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

FILE: rtl/mfam_combine.sv
// Stage 2: signed add, compares and product scaling to the q = value*1024 form.
module mfam_combine (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mfam_pkg::s1_t     in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mfam_pkg::s2_t     out_data
);

  logic                        a_gt;
  logic                        a_lt;
  logic                        a_eq;
  logic                        sa_eff;
  logic                        sb_eff;
  logic [mfam_pkg::SUM_W-1:0]  ext_a;
  logic [mfam_pkg::SUM_W-1:0]  ext_b;
  logic [mfam_pkg::SUM_W-1:0]  m;
  logic                        add_neg;
  logic                        eq_flag;
  logic                        gt_flag;
  logic [mfam_pkg::Q_W-1:0]    prod_ext;
  logic [mfam_pkg::Q_W-1:0]    mul_q;
  logic                        mul_rem;
  logic                        mul_under;
  logic                        mul_neg;
  logic signed [5:0]           lsh_full;
  logic [5:0]                  rsh;
  logic [5:0]                  k;
  logic [mfam_pkg::Q_W-1:0]    rq;
  mfam_pkg::s2_t               data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    a_gt  = in_data.mag_a > in_data.mag_b;
    a_lt  = in_data.mag_a < in_data.mag_b;
    a_eq  = in_data.mag_a == in_data.mag_b;
    ext_a = mfam_pkg::SUM_W'(in_data.mag_a);
    ext_b = mfam_pkg::SUM_W'(in_data.mag_b);

    if (in_data.neg_a == in_data.neg_b) begin
      m       = ext_a + ext_b;
      add_neg = in_data.neg_a && !(in_data.zero_a && in_data.zero_b);
    end else if (a_gt) begin
      m       = ext_a - ext_b;
      add_neg = in_data.neg_a;
    end else begin
      m       = ext_b - ext_a;
      add_neg = in_data.neg_b && a_lt;
    end

    sa_eff  = in_data.neg_a && !in_data.zero_a;
    sb_eff  = in_data.neg_b && !in_data.zero_b;
    eq_flag = a_eq && ((in_data.neg_a == in_data.neg_b) || in_data.zero_a);
    unique case ({sa_eff, sb_eff})
      2'b00:   gt_flag = a_gt;
      2'b01:   gt_flag = 1'b1;
      2'b10:   gt_flag = 1'b0;
      default: gt_flag = a_lt;
    endcase

    // product scaling: q = prod * 2^(e-10)
    prod_ext = mfam_pkg::Q_W'(in_data.prod);
    lsh_full = in_data.exp_sum - 6'sd10;
    rsh      = 6'd10 - $unsigned(in_data.exp_sum);
    k        = (~$unsigned(in_data.exp_sum)) - 6'd4;
    rq       = prod_ext >> rsh;
    if (in_data.exp_sum >= 6'sd10) begin
      mul_q   = prod_ext << lsh_full[4:0];
      mul_rem = 1'b0;
    end else begin
      mul_q   = rq;
      mul_rem = (rq << rsh) != prod_ext;
    end
    mul_under = 1'b0;
    if ((in_data.prod != '0) && (in_data.exp_sum <= -6'sd5)) begin
      if (k >= 6'd20) begin
        mul_under = 1'b1;
      end else begin
        mul_under = {1'b0, in_data.prod} <= (21'd1 << k[4:0]);
      end
    end
    mul_neg = (in_data.prod != '0) && (in_data.neg_a ^ in_data.neg_b);

    unique case (in_data.action)
      mfam_pkg::ACT_ADD: begin
        data_next.neg   = add_neg;
        data_next.q     = mfam_pkg::Q_W'(m[mfam_pkg::SUM_W-1:16]);
        data_next.rem   = (m[15:0] != '0);
        data_next.under = (m[mfam_pkg::SUM_W-1:2] == '0) && (m[1] ^ m[0]);
        data_next.flag  = 1'b0;
      end
      mfam_pkg::ACT_MUL: begin
        data_next.neg   = mul_neg;
        data_next.q     = mul_q;
        data_next.rem   = mul_rem;
        data_next.under = mul_under;
        data_next.flag  = 1'b0;
      end
      mfam_pkg::ACT_EQ: begin
        data_next.neg   = 1'b0;
        data_next.q     = '0;
        data_next.rem   = 1'b0;
        data_next.under = 1'b0;
        data_next.flag  = eq_flag;
      end
      default: begin
        data_next.neg   = 1'b0;
        data_next.q     = '0;
        data_next.rem   = 1'b0;
        data_next.under = 1'b0;
        data_next.flag  = gt_flag;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

FILE: rtl/mfam_limit.sv
// Stage 3: overflow/underflow decision and normalizing exponent search.
module mfam_limit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mfam_pkg::s2_t     in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mfam_pkg::s3_t     out_data
);

  logic                       over;
  logic [mfam_pkg::EX_W-1:0]  ex;
  mfam_pkg::s3_t              data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    over = (in_data.q > mfam_pkg::Q_LIMIT)
        || ((in_data.q == mfam_pkg::Q_LIMIT) && in_data.rem);
    ex = '0;
    for (int i = 10; i < mfam_pkg::QN_W; i++) begin
      if (in_data.q[i]) begin
        ex = mfam_pkg::EX_W'(i - 9);
      end
    end

    data_next.neg  = in_data.neg;
    data_next.q    = in_data.q[mfam_pkg::QN_W-1:0];
    data_next.ex   = ex;
    data_next.flag = in_data.flag;
    priority if (over) begin
      data_next.err = mfam_pkg::ERR_OVER;
    end else if (in_data.under) begin
      data_next.err = mfam_pkg::ERR_UNDER;
    end else begin
      data_next.err = mfam_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

FILE: rtl/mfam_pack.sv
// Stage 4: significand shift and result word packing into the output register.
module mfam_pack (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mfam_pkg::s3_t     in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mfam_pkg::res_t    out_data
);

  logic [mfam_pkg::QN_W-1:0]  shifted;
  mfam_pkg::res_t             data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    shifted = in_data.q >> in_data.ex;
    data_next.compare_flag = in_data.flag;
    data_next.error_code   = in_data.err;
    if (in_data.err != mfam_pkg::ERR_NONE) begin
      data_next.result_word = '0;
    end else begin
      data_next.result_word = {in_data.neg, 1'b0, in_data.ex, shifted[9:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
